// ===== hdl/aip_pkg.sv =====
// Package for the ASCII integer parser: status and register index codes,
// character constants, keyword patterns, the digit decode and the whitespace test.
// No dependencies.
package aip_pkg;

    typedef logic [1:0] t_status;
    typedef logic [1:0] t_cfg_index;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NO_DIGITS = 2'd1;
    localparam t_status ST_RANGE     = 2'd2;
    localparam t_status ST_TOO_LONG  = 2'd3;

    localparam t_cfg_index CFG_SIGNED_MODE = 2'd0;
    localparam t_cfg_index CFG_LOWER_LIMIT = 2'd1;
    localparam t_cfg_index CFG_UPPER_LIMIT = 2'd2;

    localparam logic [63:0] RST_LOWER_LIMIT = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] RST_UPPER_LIMIT = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SIGN_BIT        = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [31:0] KW_IMAX = "imax";
    localparam logic [31:0] KW_IMIN = "imin";
    localparam logic [31:0] KW_UMAX = "umax";

    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // Value of a hexadecimal digit character, or DIGIT_NONE for anything else.
    function automatic logic [4:0] f_digit(input logic [7:0] c);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= CH_0 && c <= CH_9) begin
            d = {1'b0, c[3:0]};
        end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            d = 5'(c[3:0]) + 5'd9;
        end
        return d;
    endfunction

    function automatic logic f_is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ===== hdl/ascii_integer_parser.sv =====
// ASCII integer parser top level: byte stream in, one result per string out.
// The transfer of the zero byte loads the evaluation stage, which passes its result
// on to the output register that drives o_res_valid; each stage holds under backpressure.
// Throughput: one byte per cycle while o_char_ready is high; decimal, octal and hex
// accumulators run in parallel, each doing one constant multiply-add per byte.
// Reset (synchronous, active low) empties the pipeline and the string state
// and loads the configuration registers with signed mode and the default limits.
// Depends on aip_pkg.
module ascii_integer_parser #(
    parameter int MAX_LEN = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  aip_pkg::t_cfg_index  i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_char_valid,
    output logic                 o_char_ready,
    input  logic [7:0]           i_character,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic                 o_success,
    output aip_pkg::t_status     o_status,
    output logic [63:0]          o_number,
    output logic [7:0]           o_consumed
);
    import aip_pkg::*;

    localparam int POS_W  = $clog2(MAX_LEN + 2);
    localparam int USED_W = (POS_W > 8) ? POS_W : 8;

    localparam logic [1:0] D_WS     = 2'd0;
    localparam logic [1:0] D_SIGNED = 2'd1;
    localparam logic [1:0] D_DIGITS = 2'd2;
    localparam logic [1:0] D_DONE   = 2'd3;

    // Configuration registers.
    logic        r_signed_mode;
    logic [63:0] r_lower_limit;
    logic [63:0] r_upper_limit;

    // String state.
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_head [0:3];

    logic [1:0]       r_dec_phase, n_dec_phase;
    logic             r_dec_neg, n_dec_neg;
    logic             r_dec_any, n_dec_any;
    logic             r_dec_ovf, n_dec_ovf;
    logic [63:0]      r_dec_mag, n_dec_mag;
    logic [POS_W-1:0] r_dec_end, n_dec_end;

    logic             r_oct_run, r_oct_any, r_oct_ovf;
    logic [63:0]      r_oct_mag;
    logic [POS_W-1:0] r_oct_end;

    logic             r_hex_run, r_hex_any, r_hex_ovf;
    logic [63:0]      r_hex_mag;
    logic [POS_W-1:0] r_hex_end;

    // Evaluation stage and output register.
    logic             r_a_valid;
    t_status          r_a_status;
    logic             r_a_check;
    logic [63:0]      r_a_value;
    logic [POS_W-1:0] r_a_used;

    logic             r_o_valid;
    t_status          r_o_status;
    logic [63:0]      r_o_number;
    logic [7:0]       r_o_consumed;

    logic             char_xfer, term, a_free, o_free;
    logic [4:0]       dig;
    logic [67:0]      dec_wide, dec_prod;
    logic [POS_W-1:0] pos_inc;

    assign o_cfg_ready  = 1'b1;
    assign o_free       = !r_o_valid || i_res_ready;
    assign a_free       = !r_a_valid || o_free;
    assign o_char_ready = a_free;
    assign char_xfer    = i_char_valid && o_char_ready;
    assign term         = char_xfer && (i_character == CH_NUL);
    assign dig          = f_digit(i_character);
    assign pos_inc      = r_pos + POS_W'(1);
    assign dec_wide     = {4'b0, r_dec_mag};
    assign dec_prod     = (dec_wide << 3) + (dec_wide << 1) + 68'(dig);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
            r_lower_limit <= RST_LOWER_LIMIT;
            r_upper_limit <= RST_UPPER_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                CFG_LOWER_LIMIT: r_lower_limit <= i_cfg_data;
                CFG_UPPER_LIMIT: r_upper_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decimal scanner: whitespace, optional sign, then decimal digits.
    always_comb begin
        n_dec_phase = r_dec_phase;
        n_dec_neg   = r_dec_neg;
        n_dec_any   = r_dec_any;
        n_dec_ovf   = r_dec_ovf;
        n_dec_mag   = r_dec_mag;
        n_dec_end   = r_dec_end;
        unique case (r_dec_phase) inside
            D_WS: begin
                if (dig < 5'd10) begin
                    n_dec_phase = D_DIGITS;
                    n_dec_any   = 1'b1;
                    n_dec_ovf   = r_dec_ovf || (dec_prod[67:64] != 4'd0);
                    n_dec_mag   = dec_prod[63:0];
                    n_dec_end   = pos_inc;
                end else if (i_character == CH_PLUS || i_character == CH_MINUS) begin
                    n_dec_phase = D_SIGNED;
                    n_dec_neg   = (i_character == CH_MINUS);
                end else if (!f_is_space(i_character)) begin
                    n_dec_phase = D_DONE;
                end
            end
            D_SIGNED, D_DIGITS: begin
                if (dig < 5'd10) begin
                    n_dec_phase = D_DIGITS;
                    n_dec_any   = 1'b1;
                    n_dec_ovf   = r_dec_ovf || (dec_prod[67:64] != 4'd0);
                    n_dec_mag   = dec_prod[63:0];
                    n_dec_end   = pos_inc;
                end else begin
                    n_dec_phase = D_DONE;
                end
            end
            D_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || term) begin
            r_pos       <= '0;
            r_head[0]   <= CH_NUL;
            r_head[1]   <= CH_NUL;
            r_head[2]   <= CH_NUL;
            r_head[3]   <= CH_NUL;
            r_dec_phase <= D_WS;
            r_dec_neg   <= 1'b0;
            r_dec_any   <= 1'b0;
            r_dec_ovf   <= 1'b0;
            r_dec_mag   <= '0;
            r_dec_end   <= '0;
            r_oct_run   <= 1'b1;
            r_oct_any   <= 1'b0;
            r_oct_ovf   <= 1'b0;
            r_oct_mag   <= '0;
            r_oct_end   <= '0;
            r_hex_run   <= 1'b1;
            r_hex_any   <= 1'b0;
            r_hex_ovf   <= 1'b0;
            r_hex_mag   <= '0;
            r_hex_end   <= '0;
        end else if (char_xfer) begin
            if (r_pos <= POS_W'(MAX_LEN)) begin
                r_pos <= pos_inc;
            end
            if (r_pos < POS_W'(4)) begin
                r_head[r_pos[1:0]] <= i_character;
            end
            r_dec_phase <= n_dec_phase;
            r_dec_neg   <= n_dec_neg;
            r_dec_any   <= n_dec_any;
            r_dec_ovf   <= n_dec_ovf;
            r_dec_mag   <= n_dec_mag;
            r_dec_end   <= n_dec_end;
            if (r_oct_run) begin
                if (dig < 5'd8) begin
                    r_oct_any <= 1'b1;
                    r_oct_ovf <= r_oct_ovf || (r_oct_mag[63:61] != 3'd0);
                    r_oct_mag <= {r_oct_mag[60:0], dig[2:0]};
                    r_oct_end <= pos_inc;
                end else begin
                    r_oct_run <= 1'b0;
                end
            end
            if (r_hex_run && r_pos >= POS_W'(2)) begin
                if (dig < DIGIT_NONE) begin
                    r_hex_any <= 1'b1;
                    r_hex_ovf <= r_hex_ovf || (r_hex_mag[63:60] != 4'd0);
                    r_hex_mag <= {r_hex_mag[59:0], dig[3:0]};
                    r_hex_end <= pos_inc;
                end else begin
                    r_hex_run <= 1'b0;
                end
            end
        end
    end

    // End of string: pick the base, keywords and the magnitude checks.
    logic [31:0]      head32;
    logic             is_hex_pfx, is_oct_pfx, use_hex, use_oct;
    logic             kw_hit, minus_fail, sel_any, sel_ovf, sel_neg, range_bad;
    logic [63:0]      kw_val, sel_mag, sel_v;
    logic [POS_W-1:0] kw_used, sel_end;
    t_status          a_status;

    assign head32     = {r_head[0], r_head[1], r_head[2], r_head[3]};
    assign is_hex_pfx = (r_head[0] == CH_0) && (r_head[1] == CH_LX || r_head[1] == CH_UX);
    assign is_oct_pfx = (r_head[0] == CH_0) && (r_head[1] >= CH_0 && r_head[1] <= CH_7);
    assign use_hex    = is_hex_pfx && r_hex_any;
    assign use_oct    = is_oct_pfx || (is_hex_pfx && !r_hex_any);
    assign minus_fail = !r_signed_mode && (r_head[0] == CH_MINUS) && (r_head[1] != CH_1);

    always_comb begin
        kw_hit  = 1'b0;
        kw_val  = r_upper_limit;
        kw_used = POS_W'(4);
        if (r_signed_mode) begin
            if (head32 == KW_IMAX && r_upper_limit != 64'd0) begin
                kw_hit = 1'b1;
            end else if (head32 == KW_IMIN && r_lower_limit != 64'd0) begin
                kw_hit = 1'b1;
                kw_val = r_lower_limit;
            end
        end else begin
            if (head32 == KW_IMAX) begin
                kw_hit = 1'b1;
                kw_val = r_upper_limit >> 1;
            end else if (head32 == KW_UMAX) begin
                kw_hit = 1'b1;
            end else if (r_head[0] == CH_MINUS && r_head[1] == CH_1) begin
                kw_hit  = 1'b1;
                kw_used = POS_W'(2);
            end
        end
    end

    always_comb begin
        if (use_hex) begin
            sel_any = r_hex_any;
            sel_ovf = r_hex_ovf;
            sel_mag = r_hex_mag;
            sel_end = r_hex_end;
            sel_neg = 1'b0;
            sel_v   = r_hex_mag;
        end else if (use_oct) begin
            sel_any = r_oct_any;
            sel_ovf = r_oct_ovf;
            sel_mag = r_oct_mag;
            sel_end = r_oct_end;
            sel_neg = 1'b0;
            sel_v   = r_oct_mag;
        end else begin
            sel_any = r_dec_any;
            sel_ovf = r_dec_ovf;
            sel_mag = r_dec_mag;
            sel_end = r_dec_end;
            sel_neg = r_dec_neg;
            sel_v   = r_dec_neg ? (64'd0 - r_dec_mag) : r_dec_mag;
        end
        range_bad = sel_mag[63] && (!sel_neg || (sel_mag[62:0] != 63'd0));
        if (r_pos > POS_W'(MAX_LEN)) begin
            a_status = ST_TOO_LONG;
        end else if (kw_hit) begin
            a_status = ST_OK;
        end else if (minus_fail || !sel_any) begin
            a_status = ST_NO_DIGITS;
        end else if (sel_ovf || (r_signed_mode && range_bad)) begin
            a_status = ST_RANGE;
        end else begin
            a_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= term;
        end
        if (term) begin
            r_a_status <= a_status;
            r_a_check  <= (a_status == ST_OK) && !kw_hit;
            r_a_value  <= kw_hit ? kw_val : sel_v;
            r_a_used   <= kw_hit ? kw_used : sel_end;
        end
    end

    // Limit check against the configured range.
    logic              limit_bad, b_ok;
    t_status           b_status;
    logic [USED_W-1:0] used_ext;

    always_comb begin
        if (r_signed_mode) begin
            limit_bad = ((r_a_value ^ SIGN_BIT) < (r_lower_limit ^ SIGN_BIT))
                     || ((r_a_value ^ SIGN_BIT) > (r_upper_limit ^ SIGN_BIT));
        end else begin
            limit_bad = r_a_value > r_upper_limit;
        end
        b_status = (r_a_check && limit_bad) ? ST_RANGE : r_a_status;
        b_ok     = (b_status == ST_OK);
        used_ext = USED_W'(r_a_used);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= r_a_valid;
        end
        if (o_free && r_a_valid) begin
            r_o_status   <= b_status;
            r_o_number   <= b_ok ? r_a_value : 64'd0;
            r_o_consumed <= b_ok ? used_ext[7:0] : 8'd0;
        end
    end

    assign o_res_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_success   = (r_o_status == ST_OK);
    assign o_number    = r_o_number;
    assign o_consumed  = r_o_consumed;

    a_fail_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_success) |-> (o_number == 64'd0 && o_consumed == 8'd0))
        else $error("Failed result carries a nonzero number or count.");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_LEN + 1))
        else $error("Position counter passed its saturation point.");

    a_term_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        term |=> (r_a_valid && r_pos == '0 && r_dec_phase == D_WS))
        else $error("End of string did not start evaluation and clear the scanners.");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !o_free) |=> (r_a_valid && $stable(r_a_value)))
        else $error("Evaluation stage lost or changed a result under backpressure.");

    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !o_free) |-> !o_char_ready)
        else $error("Input taken while the evaluation stage is blocked.");

endmodule
